// ===== design/fixed_pool_slot_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the fixed pool slot allocator
// Shared property forms used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef FIXED_POOL_SLOT_ALLOCATOR_ASSERT_SVH
`define FIXED_POOL_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, quiet during reset
`define FPSA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fpsa: same-cycle property failed");

// Next-cycle implication, sampled on clk_i, quiet during reset
`define FPSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fpsa: next-cycle property failed");

`endif

// ===== design/fpsa_pkg.sv =====
// ----------------------------------------------------------------------------
// fpsa_pkg
// Types and constants shared by the fixed pool slot allocator and its checker.
// ----------------------------------------------------------------------------
package fpsa_pkg;

  // Pool size and derived widths
  localparam int unsigned POOL_SLOTS = 4096;
  localparam int unsigned SLOT_AW    = $clog2(POOL_SLOTS);
  localparam int unsigned SLOT_W     = 12;
  localparam int unsigned COUNT_W    = 13;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 40;

  // Pool size as a count-width constant for compares
  localparam logic [COUNT_W-1:0] POOL_LIMIT = COUNT_W'(POOL_SLOTS);

  // Request kinds
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EXHAUSTED  = 2'd1,
    ST_NOT_IN_USE = 2'd2
  } status_e;

endpackage

// ===== design/fixed_pool_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// fixed_pool_slot_allocator
// Free-list slot allocator over a fixed pool, with link and busy memories.
// ----------------------------------------------------------------------------
// Each request has a read step and an update step: in the cycle it is accepted the block
// reads the free-list link at the current head and the busy bit of the named
// slot from two single-port synchronous memories, and in the S_EXEC state it
// updates the head, counters and memories and loads the result register.
// No new request is accepted until this read-then-update pair is complete;
// a result that is not taken holds the update step until it is. Allocation
// reuses the most recently freed slot, then the lowest never-used slot, else
// reports the pool exhausted. No clearing pass is needed after reset: a busy
// bit at or above the fresh-slot pointer is treated as clear.
// ----------------------------------------------------------------------------
module fixed_pool_slot_allocator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request channel
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [fpsa_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [11:0] slot
  input  logic                               s_axis_tuser,  // [0] op
  // result channel
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [fpsa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // [11:0] granted,
                                                            // [23:12] high_water,
                                                            // [36:24] in_use
  output logic [1:0]                         m_axis_tuser   // [1:0] status
);
  import fpsa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  // Allocator registers
  logic [SLOT_AW-1:0] head_q, head_d;
  logic               nonempty_q, nonempty_d;
  logic [COUNT_W-1:0] fresh_q, fresh_d;
  logic [SLOT_W-1:0]  peak_q, peak_d;
  logic [COUNT_W-1:0] live_q, live_d;

  // Captured request
  op_e                op_q;
  logic [SLOT_W-1:0]  slot_q;

  // Memories and their read data
  logic [SLOT_AW-1:0] link_mem [POOL_SLOTS];
  logic               busy_mem [POOL_SLOTS];
  logic [SLOT_AW-1:0] link_rd_q;
  logic               busy_rd_q;

  // Write ports
  logic               link_we;
  logic [SLOT_AW-1:0] link_wa, link_wd;
  logic               busy_we;
  logic [SLOT_AW-1:0] busy_wa;
  logic               busy_wd;

  // Result register
  logic               out_valid_q;
  status_e            status_q, status_d;
  logic [SLOT_W-1:0]  granted_q, granted_d;
  logic [SLOT_W-1:0]  high_q;
  logic [COUNT_W-1:0] in_use_q;

  logic               accept;
  logic               fire;
  logic [SLOT_W-1:0]  in_slot;
  logic               slot_busy;
  logic [SLOT_AW-1:0] got;

  assign in_slot       = s_axis_tdata[SLOT_W-1:0];
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign fire          = (state_q == S_EXEC) && (!out_valid_q || m_axis_tready);

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_e'(s_axis_tuser);
      slot_q <= in_slot;
    end
  end

  // Link memory: read head on accept, write on a successful free
  always_ff @(posedge clk_i) begin
    if (accept) begin
      link_rd_q <= link_mem[head_q];
    end
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
  end

  // Busy memory: read named slot on accept, write on a grant or a successful free
  always_ff @(posedge clk_i) begin
    if (accept) begin
      busy_rd_q <= busy_mem[in_slot[SLOT_AW-1:0]];
    end
    if (busy_we) begin
      busy_mem[busy_wa] <= busy_wd;
    end
  end

  // Slot is busy only if inside the pool and below the fresh pointer
  assign slot_busy = ({1'b0, slot_q} < POOL_LIMIT) &&
                     ({1'b0, slot_q} < fresh_q) && busy_rd_q;

  // Update cycle: decide the result and the new allocator state
  always_comb begin
    head_d     = head_q;
    nonempty_d = nonempty_q;
    fresh_d    = fresh_q;
    peak_d     = peak_q;
    live_d     = live_q;
    status_d   = ST_OK;
    granted_d  = '0;
    link_we    = 1'b0;
    link_wa    = slot_q[SLOT_AW-1:0];
    link_wd    = head_q;
    busy_we    = 1'b0;
    busy_wa    = slot_q[SLOT_AW-1:0];
    busy_wd    = 1'b0;
    got        = head_q;

    unique case (op_q)
      OP_ALLOC: begin
        priority if (nonempty_q) begin
          // pop the free list; a self link marks its tail
          got = head_q;
          if (link_rd_q == head_q) begin
            nonempty_d = 1'b0;
            head_d     = '0;
          end else begin
            head_d     = link_rd_q;
          end
        end else if (fresh_q < POOL_LIMIT) begin
          got     = fresh_q[SLOT_AW-1:0];
          fresh_d = fresh_q + COUNT_W'(1);
        end else begin
          status_d = ST_EXHAUSTED;
        end
        if (status_d == ST_OK) begin
          granted_d = SLOT_W'(got);
          busy_we   = fire;
          busy_wa   = got;
          busy_wd   = 1'b1;
          live_d    = live_q + COUNT_W'(1);
          if (SLOT_W'(got) > peak_q) begin
            peak_d = SLOT_W'(got);
          end
        end
      end
      OP_FREE: begin
        granted_d = slot_q;
        if (!slot_busy) begin
          status_d = ST_NOT_IN_USE;
        end else begin
          // push onto the free list
          link_we    = fire;
          link_wd    = nonempty_q ? head_q : slot_q[SLOT_AW-1:0];
          head_d     = slot_q[SLOT_AW-1:0];
          nonempty_d = 1'b1;
          busy_we    = fire;
          busy_wd    = 1'b0;
          live_d     = live_q - COUNT_W'(1);
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // Sequence: accept, then update once the result register is free
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_EXEC;
      S_EXEC:  if (fire)   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      nonempty_q  <= 1'b0;
      fresh_q     <= '0;
      peak_q      <= '0;
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fire) begin
        head_q     <= head_d;
        nonempty_q <= nonempty_d;
        fresh_q    <= fresh_d;
        peak_q     <= peak_d;
        live_q     <= live_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q  <= status_d;
      granted_q <= granted_d;
      high_q    <= peak_d;
      in_use_q  <= live_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {3'b000, in_use_q, high_q, granted_q};

endmodule

// ===== design/fpsa_checker.sv =====
// ----------------------------------------------------------------------------
// fpsa_checker
// Port-level checks on the fixed pool slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "fixed_pool_slot_allocator_assert.svh"

module fpsa_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic [fpsa_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input logic                               s_axis_tuser,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [fpsa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input logic [1:0]                         m_axis_tuser
);
  import fpsa_pkg::*;

  logic in_txn;
  logic out_stall;

  assign in_txn    = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // A stalled result keeps its payload
  `FPSA_ASSERT_NEXT(a_result_held, out_stall, $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // Only defined status codes appear
  `FPSA_ASSERT_NOW(a_status_code, m_axis_tvalid, m_axis_tuser == ST_OK || m_axis_tuser == ST_EXHAUSTED || m_axis_tuser == ST_NOT_IN_USE)

  // An exhausted pool grants slot zero
  `FPSA_ASSERT_NOW(a_exhausted_zero, m_axis_tvalid && m_axis_tuser == ST_EXHAUSTED, m_axis_tdata[SLOT_W-1:0] == '0)

  // A request transaction is never taken in the cycle right after another
  `FPSA_ASSERT_NEXT(a_two_cycle_gap, in_txn, !s_axis_tready)

  // The in-use count never exceeds the pool
  `FPSA_ASSERT_NOW(a_in_use_bound, m_axis_tvalid, m_axis_tdata[2*SLOT_W+COUNT_W-1:2*SLOT_W] <= POOL_LIMIT)

endmodule

bind fixed_pool_slot_allocator fpsa_checker u_fpsa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
